FILE: hdl/prle_pkg.sv
// ----------------------------------------------------------------------------
// prle_pkg
// Shared types and constants for the priority ready-list engine.
// ----------------------------------------------------------------------------
package prle_pkg;

   localparam int NUM_PRIOS_DEF = 32;
   localparam int NUM_TASKS_DEF = 32;

   localparam logic [1:0] FUNC_INSERT  = 2'd0;
   localparam logic [1:0] FUNC_REMOVE  = 2'd1;
   localparam logic [1:0] FUNC_ROTATE  = 2'd2;
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_WRITE,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic read;
      logic exec;
      logic write;
      logic load_out;
   } cmd_type;

endpackage

FILE: hdl/prle_ram.sv
// ----------------------------------------------------------------------------
// prle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: hdl/prle_ctrl.sv
// ----------------------------------------------------------------------------
// prle_ctrl
// Sequencer: capture, read, execute, write back, present the result.
// ----------------------------------------------------------------------------
module prle_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output prle_pkg::cmd_type cmd
);

   prle_pkg::state_type state_ff, state_in;
   logic                out_valid_ff, out_valid_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prle_pkg::ST_IDLE:  if (req_tvalid) state_in = prle_pkg::ST_READ;
         prle_pkg::ST_READ:  state_in = prle_pkg::ST_EXEC;
         prle_pkg::ST_EXEC:  state_in = prle_pkg::ST_WRITE;
         prle_pkg::ST_WRITE: state_in = prle_pkg::ST_OUT;
         prle_pkg::ST_OUT: begin
            if (!out_valid_ff || rsp_tready) state_in = prle_pkg::ST_IDLE;
         end
         default: state_in = prle_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         prle_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         prle_pkg::ST_READ:  cmd.read  = 1'b1;
         prle_pkg::ST_EXEC:  cmd.exec  = 1'b1;
         prle_pkg::ST_WRITE: cmd.write = 1'b1;
         prle_pkg::ST_OUT:   cmd.load_out = !out_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // Output register valid: load in OUT, drop on transfer
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tvalid && rsp_tready) out_valid_in = 1'b0;
      if (cmd.load_out) out_valid_in = 1'b1;
   end

   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prle_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: hdl/prle_dpath.sv
// ----------------------------------------------------------------------------
// prle_dpath
// Link memories, list roots, counts and bitmap with the list update logic.
// ----------------------------------------------------------------------------
module prle_dpath #(
   parameter int NUM_PRIOS = prle_pkg::NUM_PRIOS_DEF,
   parameter int NUM_TASKS = prle_pkg::NUM_TASKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  prle_pkg::cmd_type cmd,
   input  logic [16:0]       req_tdata,
   output logic [55:0]       rsp_tdata
);

   localparam int TW = $clog2(NUM_TASKS);
   localparam int LW = TW + 1;
   localparam int PW = $clog2(NUM_PRIOS);
   localparam int CW = $clog2(NUM_TASKS + 1);
   localparam logic [LW-1:0] NONE = LW'(NUM_TASKS);

   // Captured request
   logic [1:0] func_ff;
   logic [4:0] tid_ff, prio_ff, cur_ff;

   // Per-task link state and per-priority roots
   logic [LW-1:0] next_ff [NUM_TASKS];
   logic [LW-1:0] prev_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0] linked_ff;
   logic [CW-1:0] count_ff [NUM_PRIOS];

   // Head and tail are stores read at one signal address: RAMs
   logic          root_we;
   logic [PW-1:0] root_addr;
   logic [TW-1:0] head_wd, tail_wd, head_rd, tail_rd;

   // Operation decoded in EXEC, applied in WRITE
   logic          ok_ff;
   logic [TW-1:0] nhead_ff, ntail_ff;
   logic [CW-1:0] ncount_ff;
   logic [TW-1:0] t_ff, pv_t_ff, nx_t_ff, h_ff, tl_ff;
   logic [LW-1:0] pv_ff, nx_ff;
   logic [2:0]    kind_ff;
   logic          prio_ok_ff;

   logic prio_ok, task_ok;
   logic [PW-1:0] p;
   logic [TW-1:0] t;

   assign prio_ok = 32'(prio_ff) < NUM_PRIOS;
   assign task_ok = 32'(tid_ff) < NUM_TASKS;
   assign p = PW'(prio_ff);
   assign t = TW'(tid_ff);
   assign root_addr = p;
   assign root_we = cmd.write && ok_ff && prio_ok;

   prle_ram #(.WIDTH(TW), .DEPTH(NUM_PRIOS)) u_head (
      .clock(clock), .wr_en(root_we), .wr_addr(root_addr),
      .wr_data(nhead_ff), .rd_addr(root_addr), .rd_data(head_rd));
   prle_ram #(.WIDTH(TW), .DEPTH(NUM_PRIOS)) u_tail (
      .clock(clock), .wr_en(root_we), .wr_addr(root_addr),
      .wr_data(ntail_ff), .rd_addr(root_addr), .rd_data(tail_rd));
   assign head_wd = nhead_ff;
   assign tail_wd = ntail_ff;

   localparam logic [2:0] K_NONE = 3'd0, K_INS_EMPTY = 3'd1, K_INS_TAIL = 3'd2,
      K_INS_HEAD = 3'd3, K_REMOVE = 3'd4, K_ROTATE = 3'd5;

   // Decode the operation from the read roots and links
   logic [CW-1:0] cnt;
   logic [LW-1:0] pv, nx, hnx;
   logic          pv_ok, nx_ok, ok;
   logic [2:0]    kind;
   logic [TW-1:0] nh, nt;
   logic [CW-1:0] nc;
   always_comb begin
      cnt  = prio_ok ? count_ff[p] : '0;
      pv   = prev_ff[t];
      nx   = next_ff[t];
      hnx  = next_ff[head_rd];
      pv_ok = pv != NONE;
      nx_ok = nx != NONE;
      ok = 1'b0;
      kind = K_NONE;
      nh = head_rd;
      nt = tail_rd;
      nc = cnt;
      if (prio_ok) begin
         case (func_ff)
            prle_pkg::FUNC_INSERT: begin
               if (task_ok && !linked_ff[t]) begin
                  ok = 1'b1;
                  nc = cnt + 1'b1;
                  if (cnt == '0) begin
                     kind = K_INS_EMPTY; nh = t; nt = t;
                  end else if (prio_ff == cur_ff) begin
                     kind = K_INS_TAIL; nt = t;
                  end else begin
                     kind = K_INS_HEAD; nh = t;
                  end
               end
            end
            prle_pkg::FUNC_REMOVE: begin
               if (task_ok && linked_ff[t] && cnt != '0 && (pv_ok || head_rd == t)
                   && (nx_ok || tail_rd == t)) begin
                  ok = 1'b1;
                  kind = K_REMOVE;
                  nc = (!pv_ok && !nx_ok) ? '0 : cnt - 1'b1;
                  if (!pv_ok && !nx_ok) begin
                     nh = '0; nt = '0;
                  end else if (!pv_ok) begin
                     nh = TW'(nx);
                  end else if (!nx_ok) begin
                     nt = TW'(pv);
                  end
               end
            end
            prle_pkg::FUNC_ROTATE: begin
               ok = 1'b1;
               if (cnt >= CW'(2) && head_rd != tail_rd && hnx != NONE) begin
                  kind = K_ROTATE; nh = TW'(hnx); nt = head_rd;
               end
            end
            default: ok = 1'b0;
         endcase
      end
   end

   // Capture, decode and link update registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_tdata[1:0];
         tid_ff  <= req_tdata[6:2];
         prio_ff <= req_tdata[11:7];
         cur_ff  <= req_tdata[16:12];
      end
      if (cmd.exec) begin
         ok_ff <= ok; kind_ff <= kind; prio_ok_ff <= prio_ok;
         nhead_ff <= nh; ntail_ff <= nt; ncount_ff <= nc;
         t_ff <= t; pv_ff <= pv; nx_ff <= nx;
         pv_t_ff <= TW'(pv); nx_t_ff <= TW'(nx);
         h_ff <= head_rd; tl_ff <= tail_rd;
      end
      if (reset) begin
         linked_ff <= '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            next_ff[i] <= NONE;
            prev_ff[i] <= NONE;
         end
         for (int i = 0; i < NUM_PRIOS; i++) count_ff[i] <= '0;
      end else if (cmd.write && ok_ff && prio_ok) begin
         count_ff[p] <= ncount_ff;
         case (kind_ff)
            K_INS_EMPTY: begin
               next_ff[t_ff] <= NONE; prev_ff[t_ff] <= NONE; linked_ff[t_ff] <= 1'b1;
            end
            K_INS_TAIL: begin
               next_ff[t_ff] <= NONE; prev_ff[t_ff] <= LW'(tl_ff);
               next_ff[tl_ff] <= LW'(t_ff); linked_ff[t_ff] <= 1'b1;
            end
            K_INS_HEAD: begin
               next_ff[t_ff] <= LW'(h_ff); prev_ff[t_ff] <= NONE;
               prev_ff[h_ff] <= LW'(t_ff); linked_ff[t_ff] <= 1'b1;
            end
            K_REMOVE: begin
               if (pv_ff != NONE) next_ff[pv_t_ff] <= nx_ff;
               if (nx_ff != NONE) prev_ff[nx_t_ff] <= pv_ff;
               next_ff[t_ff] <= NONE; prev_ff[t_ff] <= NONE; linked_ff[t_ff] <= 1'b0;
            end
            K_ROTATE: begin
               prev_ff[nhead_ff] <= NONE; next_ff[h_ff] <= NONE;
               prev_ff[h_ff] <= LW'(tl_ff); next_ff[tl_ff] <= LW'(h_ff);
            end
            default: ;
         endcase
      end
   end

   // Ready bitmap from counts
   logic [31:0] bitmap;
   always_comb begin
      bitmap = '0;
      for (int i = 0; i < NUM_PRIOS && i < 32; i++) bitmap[i] = count_ff[i] != '0;
   end

   // Result register
   logic [CW-1:0] rc;
   assign rc = prio_ok_ff ? count_ff[p] : '0;
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_tdata[4:0]   <= (rc != '0) ? 5'(head_wd) : 5'd0;
         rsp_tdata[9:5]   <= (rc != '0) ? 5'(tail_wd) : 5'd0;
         rsp_tdata[15:10] <= 6'(rc);
         rsp_tdata[47:16] <= bitmap;
         rsp_tdata[48]    <= !ok_ff;
         rsp_tdata[55:49] <= '0;
      end
   end

endmodule

FILE: hdl/priority_ready_list_engine.sv
// ----------------------------------------------------------------------------
// priority_ready_list_engine
// Per-priority doubly linked ready lists with a ready bitmap.
// ----------------------------------------------------------------------------
// One request is handled at a time. After the request transfer the result is
// produced by root read, decode, write back and result load, in that order; the
// head and tail root memories have a registered read. A new request is taken
// once the previous result has been loaded into the output register; while a
// result waits on the receiver, the next one is held in the result state and
// the input stays stalled.
module priority_ready_list_engine #(
   parameter int NUM_PRIOS = prle_pkg::NUM_PRIOS_DEF,
   parameter int NUM_TASKS = prle_pkg::NUM_TASKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // func[1:0] task_id[6:2] task_prio[11:7] current_prio[16:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // head_task[4:0] tail_task[9:5] entry_count[15:10]
                                   // ready_bitmap[47:16] status[48]
);

   prle_pkg::cmd_type cmd;

   prle_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .cmd(cmd));

   prle_dpath #(.NUM_PRIOS(NUM_PRIOS), .NUM_TASKS(NUM_TASKS)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .req_tdata(req_tdata[16:0]),
      .rsp_tdata(rsp_tdata));

endmodule
